// ===== rtl/core/delimited_frame_receiver_unit_macros.svh =====
// Assertion macros for the delimited frame receiver.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef DELIMITED_FRAME_RECEIVER_UNIT_MACROS_SVH
`define DELIMITED_FRAME_RECEIVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define DFR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame receiver check failed");

// Next-cycle implication
`define DFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame receiver check failed");

`else

`define DFR_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define DFR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/dfr_pkg.sv =====
`timescale 1ns / 1ps

package dfr_pkg;

   localparam int BYTE_W       = 8;
   localparam int OPCODE_W     = 2;
   localparam int READ_INDEX_W = 4;
   localparam int STATUS_W     = 3;
   localparam int COUNT_W      = 8;
   localparam int CSR_INDEX_W  = 1;

   typedef logic [BYTE_W-1:0]       byte_type;
   typedef logic [OPCODE_W-1:0]     opcode_type;
   typedef logic [READ_INDEX_W-1:0] read_index_type;
   typedef logic [STATUS_W-1:0]     status_type;
   typedef logic [COUNT_W-1:0]      count_type;
   typedef logic [CSR_INDEX_W-1:0]  csr_index_type;

   // Request opcodes
   localparam opcode_type OP_BYTE    = 2'd0;
   localparam opcode_type OP_RELEASE = 2'd1;
   localparam opcode_type OP_READ    = 2'd2;

   // Response status codes
   localparam status_type ST_IGNORED   = 3'd0;
   localparam status_type ST_STORED    = 3'd1;
   localparam status_type ST_COMPLETE  = 3'd2;
   localparam status_type ST_DROPPED   = 3'd3;
   localparam status_type ST_OVERFLOW  = 3'd4;
   localparam status_type ST_RELEASED  = 3'd5;
   localparam status_type ST_READ_DONE = 3'd6;

   // Configuration register indexes
   localparam csr_index_type CSR_START_BYTE = 1'd0;
   localparam csr_index_type CSR_END_BYTE   = 1'd1;

   localparam byte_type START_BYTE_RESET = 8'h02;
   localparam byte_type END_BYTE_RESET   = 8'h03;

   localparam count_type COUNT_MAX = 8'hFF;

endpackage

// ===== rtl/core/delimited_frame_receiver_unit.sv =====
// Start/end byte framed receiver. Each request word is a received byte, a release of the
// pending frame, or a read of one buffer slot; every request returns exactly one response
// word carrying a status code, the read byte (zero unless a read hit a slot inside the
// buffer) and the receiver state after the request. Bytes are hunted for start_byte, then
// stored up to and including end_byte, which marks the frame pending; bytes that arrive
// while a frame is pending are dropped and counted, and a frame that fills BUFFER_DEPTH
// slots without end_byte is discarded, counted, and hunting resumes. Both counters
// saturate at 255. Throughput is one request per clock: a request is decided in the cycle
// it is accepted and its response is registered at that edge (the buffer's registered read
// port supplies read data), and a new request is taken whenever the response register is
// empty or being drained. Reading a slot that was never written since reset returns an
// undefined byte. Configuration writes are meant for idle periods.
`timescale 1ns / 1ps
`include "delimited_frame_receiver_unit_macros.svh"

module delimited_frame_receiver_unit #(
   parameter int BUFFER_DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // Configuration
   input  logic                                       csr_write_enable,
   input  dfr_pkg::csr_index_type                     csr_index,
   input  dfr_pkg::byte_type                          csr_write_data,
   // Request channel
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  dfr_pkg::opcode_type                        req_opcode,
   input  dfr_pkg::byte_type                          req_byte_value,
   input  dfr_pkg::read_index_type                    req_read_index,
   // Response channel
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output dfr_pkg::status_type                        rsp_status,
   output dfr_pkg::byte_type                          rsp_read_data,
   output logic                                       rsp_frame_pending,
   output logic [$clog2(BUFFER_DEPTH+1)-1:0]          rsp_frame_length,
   output dfr_pkg::count_type                         rsp_pending_error_count,
   output dfr_pkg::count_type                         rsp_overlong_error_count
);
   import dfr_pkg::*;

   localparam int ADDR_W = $clog2(BUFFER_DEPTH);
   localparam int POS_W  = $clog2(BUFFER_DEPTH + 2);
   localparam int LEN_W  = $clog2(BUFFER_DEPTH + 1);
   localparam int EXT_W  = (ADDR_W > READ_INDEX_W) ? ADDR_W : READ_INDEX_W;

   // Configuration registers
   byte_type start_byte_ff;
   byte_type end_byte_ff;

   // Receiver state
   logic [POS_W-1:0] wpos_ff, wpos_in;
   logic             pend_ff, pend_in;
   count_type        pdrop_ff, pdrop_in;
   count_type        odrop_ff, odrop_in;

   // Response register
   logic       rsp_valid_ff;
   status_type status_ff, status_in;
   logic       rd_hit_ff, rd_hit_in;

   // Buffer access
   logic              store_we;
   logic [POS_W-1:0]  slot;
   logic [EXT_W-1:0]  rd_addr_ext;
   logic              rd_in_range;
   byte_type          store_rdata;
   logic              accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign slot        = wpos_ff - POS_W'(1);
   assign rd_addr_ext = EXT_W'(req_read_index);
   assign rd_in_range = (32'(req_read_index) < BUFFER_DEPTH);

   // Next state and status for the incoming word
   always_comb begin
      wpos_in   = wpos_ff;
      pend_in   = pend_ff;
      pdrop_in  = pdrop_ff;
      odrop_in  = odrop_ff;
      status_in = ST_IGNORED;
      rd_hit_in = 1'b0;
      store_we  = 1'b0;
      case (req_opcode)
         OP_BYTE: begin
            if (pend_ff) begin
               if (pdrop_ff != COUNT_MAX) begin
                  pdrop_in = pdrop_ff + COUNT_W'(1);
               end
               status_in = ST_DROPPED;
            end else if (wpos_ff == '0) begin
               if (req_byte_value == start_byte_ff) begin
                  wpos_in   = POS_W'(1);
                  status_in = ST_STORED;
               end
            end else begin
               // not pending, so the slot is always inside the buffer
               store_we = 1'b1;
               if (req_byte_value == end_byte_ff) begin
                  pend_in   = 1'b1;
                  wpos_in   = wpos_ff + POS_W'(1);
                  status_in = ST_COMPLETE;
               end else if (wpos_ff >= POS_W'(BUFFER_DEPTH)) begin
                  wpos_in = '0;
                  if (odrop_ff != COUNT_MAX) begin
                     odrop_in = odrop_ff + COUNT_W'(1);
                  end
                  status_in = ST_OVERFLOW;
               end else begin
                  wpos_in   = wpos_ff + POS_W'(1);
                  status_in = ST_STORED;
               end
            end
         end
         OP_RELEASE: begin
            pend_in   = 1'b0;
            wpos_in   = '0;
            status_in = ST_RELEASED;
         end
         OP_READ: begin
            rd_hit_in = rd_in_range;
            status_in = ST_READ_DONE;
         end
         default: begin
            status_in = ST_IGNORED;
         end
      endcase
   end

   dfr_frame_store #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .ADDR_W       (ADDR_W)
   ) u_store (
      .clock         (clock),
      .write_enable  (accept && store_we),
      .write_address (slot[ADDR_W-1:0]),
      .write_data    (req_byte_value),
      .read_enable   (accept && rd_hit_in),
      .read_address  (rd_addr_ext[ADDR_W-1:0]),
      .read_data     (store_rdata)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
         end_byte_ff   <= END_BYTE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_START_BYTE: start_byte_ff <= csr_write_data;
            CSR_END_BYTE:   end_byte_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Receiver state update
   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff  <= '0;
         pend_ff  <= 1'b0;
         pdrop_ff <= '0;
         odrop_ff <= '0;
      end else if (accept) begin
         wpos_ff  <= wpos_in;
         pend_ff  <= pend_in;
         pdrop_ff <= pdrop_in;
         odrop_ff <= odrop_in;
      end
   end

   // Response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         rd_hit_ff <= rd_hit_in;
      end
   end

   // State registers only move on accept, so they hold with the response word
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_status               = status_ff;
   assign rsp_read_data            = rd_hit_ff ? store_rdata : '0;
   assign rsp_frame_pending        = pend_ff;
   assign rsp_frame_length         = (wpos_ff == '0) ? '0 : LEN_W'(slot);
   assign rsp_pending_error_count  = pdrop_ff;
   assign rsp_overlong_error_count = odrop_ff;

   // Checks
   `DFR_ASSERT_IMPLY(a_pending_has_frame, clock, reset, pend_ff, wpos_ff >= POS_W'(2))
   `DFR_ASSERT_IMPLY(a_open_frame_in_buffer, clock, reset,
      !pend_ff, wpos_ff <= POS_W'(BUFFER_DEPTH))
   `DFR_ASSERT_NEXT(a_release_clears, clock, reset,
      accept && (req_opcode == OP_RELEASE), (wpos_ff == '0) && !pend_ff)
   `DFR_ASSERT_IMPLY(a_complete_sets_pending, clock, reset,
      rsp_valid_ff && (status_ff == ST_COMPLETE), pend_ff)

endmodule

// ===== rtl/core/dfr_frame_store.sv =====
`timescale 1ns / 1ps

module dfr_frame_store #(
   parameter int BUFFER_DEPTH = 16,
   parameter int ADDR_W       = 4
) (
   input  logic                clock,
   input  logic                write_enable,
   input  logic [ADDR_W-1:0]   write_address,
   input  dfr_pkg::byte_type   write_data,
   input  logic                read_enable,
   input  logic [ADDR_W-1:0]   read_address,
   output dfr_pkg::byte_type   read_data
);
   import dfr_pkg::*;

   byte_type mem [BUFFER_DEPTH];
   byte_type read_data_ff;

   // Single write port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= mem[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== verif/tb_delimited_frame_receiver_unit.sv =====
`timescale 1ns / 1ps

module tb_delimited_frame_receiver_unit;
   import dfr_pkg::*;

   localparam int DEPTH       = 16;
   localparam int LEN_W       = $clog2(DEPTH + 1);
   localparam int CYCLE_LIMIT = 400000;

   // Opcode 3 has no meaning; the block must ignore it
   localparam opcode_type OP_UNUSED = 2'd3;

   // One response word as the block should present it
   typedef struct {
      status_type       status;
      byte_type         read_data;
      logic             pending;
      logic [LEN_W-1:0] length;
      count_type        pend_cnt;
      count_type        over_cnt;
   } rsp_word_type;

   // Tracks framing state and queues the response each request must produce
   class frame_tracker;
      byte_type         start_val;
      byte_type         end_val;
      logic [LEN_W-1:0] position;
      byte_type         slots [DEPTH];
      bit               written [DEPTH];
      logic             pending;
      count_type        pend_drops;
      count_type        over_drops;
      rsp_word_type     expected_words [$];
      int               errors;
      int               checked;

      function new();
         start_val  = START_BYTE_RESET;
         end_val    = END_BYTE_RESET;
         position   = '0;
         pending    = 1'b0;
         pend_drops = '0;
         over_drops = '0;
         errors     = 0;
         checked    = 0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      function void set_register(csr_index_type idx, byte_type value);
         case (idx)
            CSR_START_BYTE: start_val = value;
            CSR_END_BYTE:   end_val   = value;
            default: ;
         endcase
      endfunction

      function count_type sat_inc(count_type c);
         return (c == COUNT_MAX) ? c : c + 1'b1;
      endfunction

      function bit is_written(read_index_type idx);
         return written[idx];
      endfunction

      function int outstanding();
         return expected_words.size();
      endfunction

      // Apply one accepted request word and queue its response
      function void note_request(opcode_type op, byte_type b, read_index_type idx);
         rsp_word_type w;
         int           slot;
         w.status    = ST_IGNORED;
         w.read_data = '0;
         case (op)
            OP_BYTE: begin
               if (pending) begin
                  pend_drops = sat_inc(pend_drops);
                  w.status   = ST_DROPPED;
               end else if (position == 0) begin
                  if (b == start_val) begin
                     position = LEN_W'(1);
                     w.status = ST_STORED;
                  end
               end else begin
                  slot          = position - 1;
                  slots[slot]   = b;
                  written[slot] = 1'b1;
                  if (b == end_val) begin
                     pending  = 1'b1;
                     position = position + 1'b1;
                     w.status = ST_COMPLETE;
                  end else if (position >= DEPTH) begin
                     // buffer full without end byte: discard, back to hunting
                     position   = '0;
                     over_drops = sat_inc(over_drops);
                     w.status   = ST_OVERFLOW;
                  end else begin
                     position = position + 1'b1;
                     w.status = ST_STORED;
                  end
               end
            end
            OP_RELEASE: begin
               pending  = 1'b0;
               position = '0;
               w.status = ST_RELEASED;
            end
            OP_READ: begin
               w.read_data = slots[idx];
               w.status    = ST_READ_DONE;
            end
            default: ;
         endcase
         w.pending  = pending;
         w.length   = (position == 0) ? '0 : position - 1'b1;
         w.pend_cnt = pend_drops;
         w.over_cnt = over_drops;
         expected_words.push_back(w);
      endfunction

      // Four-state compare, so an unknown output never slips through
      function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
         if (exp_val !== act_val) begin
            $error("%s expected %0d actual %0d", name, exp_val, act_val);
            errors++;
         end
      endfunction

      // Compare an accepted response word against the oldest expectation
      function void check_response(rsp_word_type got);
         rsp_word_type w;
         if (expected_words.size() == 0) begin
            $error("response word with no request outstanding");
            errors++;
            return;
         end
         w = expected_words.pop_front();
         checked++;
         compare_field("status", 32'(w.status), 32'(got.status));
         compare_field("read_data", 32'(w.read_data), 32'(got.read_data));
         compare_field("frame_pending", 32'(w.pending), 32'(got.pending));
         compare_field("frame_length", 32'(w.length), 32'(got.length));
         compare_field("pending_error_count", 32'(w.pend_cnt), 32'(got.pend_cnt));
         compare_field("overlong_error_count", 32'(w.over_cnt), 32'(got.over_cnt));
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_write_enable = 1'b0;
   csr_index_type    csr_index = CSR_START_BYTE;
   byte_type         csr_write_data = '0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   opcode_type       req_opcode = OP_BYTE;
   byte_type         req_byte_value = '0;
   read_index_type   req_read_index = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   status_type       rsp_status;
   byte_type         rsp_read_data;
   logic             rsp_frame_pending;
   logic [LEN_W-1:0] rsp_frame_length;
   count_type        rsp_pending_error_count;
   count_type        rsp_overlong_error_count;

   frame_tracker tracker;
   bit           idle_on = 1'b1;
   int           stall_left = 0;
   int           cycles = 0;
   int           words_sent = 0;
   int           settings_used = 1;

   delimited_frame_receiver_unit #(.BUFFER_DEPTH(DEPTH)) uut (
      .clock                    (clock),
      .reset                    (reset),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_opcode               (req_opcode),
      .req_byte_value           (req_byte_value),
      .req_read_index           (req_read_index),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_status               (rsp_status),
      .rsp_read_data            (rsp_read_data),
      .rsp_frame_pending        (rsp_frame_pending),
      .rsp_frame_length         (rsp_frame_length),
      .rsp_pending_error_count  (rsp_pending_error_count),
      .rsp_overlong_error_count (rsp_overlong_error_count)
   );

   always #4 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Response side stalls in random bursts; it never stalls once idle_on is cleared
   always @(negedge clock) begin
      if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 9) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check every accepted response word
   always @(posedge clock) begin
      rsp_word_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status   = rsp_status;
         got.read_data = rsp_read_data;
         got.pending  = rsp_frame_pending;
         got.length   = rsp_frame_length;
         got.pend_cnt = rsp_pending_error_count;
         got.over_cnt = rsp_overlong_error_count;
         tracker.check_response(got);
      end
   end

   // Present one request word and hold it until accepted; called at a falling edge
   task automatic send_word(opcode_type op, byte_type b, read_index_type idx);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_byte_value <= b;
      req_read_index <= idx;
      do @(posedge clock); while (!(req_valid && !req_stall));
      tracker.note_request(op, b, idx);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_byte(byte_type b);
      send_word(OP_BYTE, b, read_index_type'($urandom_range(0, 15)));
   endtask

   // Reads only slots written since reset; otherwise release instead
   task automatic send_read(read_index_type idx);
      if (tracker.is_written(idx))
         send_word(OP_READ, byte_type'($urandom), idx);
      else
         send_word(OP_RELEASE, byte_type'($urandom), idx);
   endtask

   function automatic byte_type data_byte();
      byte_type v;
      v = byte_type'($urandom);
      if (v == tracker.end_val) v = v ^ 8'h01;
      return v;
   endfunction

   // Wait until every response is in, then change both registers
   task automatic set_config(byte_type s, byte_type e);
      req_valid <= 1'b0;
      while (tracker.outstanding() > 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_START_BYTE;
      csr_write_data   <= s;
      @(negedge clock);
      tracker.set_register(CSR_START_BYTE, s);
      csr_index      <= CSR_END_BYTE;
      csr_write_data <= e;
      @(negedge clock);
      tracker.set_register(CSR_END_BYTE, e);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   // Mostly well-formed frames with random content, plus overlong, cut-short and noise
   task automatic traffic(int target);
      int         first;
      int         kind;
      opcode_type op;
      first = words_sent;
      while (words_sent - first < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            repeat ($urandom_range(0, 2)) send_byte(byte_type'($urandom));
            send_byte(tracker.start_val);
            repeat ($urandom_range(0, 14))
               send_byte(($urandom_range(0, 7) == 0) ? tracker.start_val : data_byte());
            send_byte(tracker.end_val);
            repeat ($urandom_range(0, 3)) send_byte(byte_type'($urandom));
            repeat ($urandom_range(0, 3))
               send_read(read_index_type'($urandom_range(0, 15)));
            if ($urandom_range(0, 7) != 0)
               send_word(OP_RELEASE, byte_type'($urandom),
                         read_index_type'($urandom_range(0, 15)));
         end else if (kind < 70) begin
            send_byte(tracker.start_val);
            repeat (DEPTH) send_byte(data_byte());
         end else if (kind < 80) begin
            send_byte(tracker.start_val);
            repeat ($urandom_range(1, 10)) send_byte(data_byte());
            send_word(OP_RELEASE, byte_type'($urandom),
                      read_index_type'($urandom_range(0, 15)));
         end else begin
            op = opcode_type'($urandom_range(0, 3));
            if (op == OP_READ)
               send_read(read_index_type'($urandom_range(0, 15)));
            else
               send_word(op, byte_type'($urandom), read_index_type'($urandom_range(0, 15)));
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Hunting: non-start byte, unused opcode, release with nothing pending
      send_byte(8'h00);
      send_word(OP_UNUSED, 8'hFF, 4'hF);
      send_word(OP_RELEASE, 8'h5A, 4'h0);

      // Open, start byte as data, extremes, then fill the buffer without an end byte
      send_byte(START_BYTE_RESET);
      send_byte(START_BYTE_RESET);
      send_byte(8'hFF);
      send_byte(8'h00);
      repeat (DEPTH - 3) send_byte(data_byte());
      send_read(4'h0);
      send_read(4'hF);

      // Short frame, byte dropped while pending, read back, release
      send_byte(START_BYTE_RESET);
      send_byte(END_BYTE_RESET);
      send_byte(8'hA5);
      send_read(4'h0);
      send_word(OP_RELEASE, 8'h00, 4'h0);

      // Start equal to end: first opens, second completes
      set_config(8'hFF, 8'hFF);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_read(4'h0);
      send_word(OP_RELEASE, 8'hFF, 4'hF);
      traffic(70);

      // Long run of drops while pending drives the drop counter into saturation
      set_config(8'h00, 8'hFF);
      send_word(OP_RELEASE, 8'h00, 4'h0);
      send_byte(8'h00);
      send_byte(8'hFF);
      repeat (270) send_byte(byte_type'($urandom));
      send_word(OP_RELEASE, 8'h00, 4'h0);
      traffic(70);

      set_config(8'hFF, 8'h00);
      traffic(70);
      set_config(byte_type'($urandom), byte_type'($urandom));
      traffic(70);
      set_config(8'h00, 8'h00);
      traffic(70);
      set_config(byte_type'($urandom), byte_type'($urandom));
      traffic(70);

      // Last stretch at full rate on both sides
      idle_on = 1'b0;
      set_config(START_BYTE_RESET, END_BYTE_RESET);
      traffic(70);

      req_valid <= 1'b0;
      while (tracker.outstanding() > 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (tracker.outstanding() > 0) begin
         $error("%0d expected response words never arrived", tracker.outstanding());
         tracker.errors++;
      end

      $display("Sent %0d request words under %0d start/end byte settings;",
               words_sent, settings_used);
      $display("%0d responses compared.", tracker.checked);
      if (tracker.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
